/* rtl/estm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transform builder package
// Shared types, constants and fixed-point helpers of the transform builder.
// ----------------------------------------------------------------------------
package estm_pkg;

   // Number of CORDIC iterations and the size of the arctangent table.
   localparam int CORDIC_STEPS = 16;
   localparam int TAB_LEN      = 24;
   localparam int NSTEP        = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
   // Three merge stages follow the CORDIC stages.
   localparam int LAT          = NSTEP + 3;

   // Internal datapath word: signed Q3.30.
   localparam int CW = 34;
   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

   typedef struct packed {
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic signed [23:0] scale_x;
      logic signed [23:0] scale_y;
      logic signed [23:0] scale_z;
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic signed [31:0] shift_z;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m03;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m13;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic signed [31:0] m23;
   } rsp_data_type;

   // Arctangent of 2^-i as a 32-bit binary angle.
   function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CW-1:0] v;
      case (idx)
         5'd0:  v = 34'sd536870912;
         5'd1:  v = 34'sd316933406;
         5'd2:  v = 34'sd167458907;
         5'd3:  v = 34'sd85004756;
         5'd4:  v = 34'sd42667331;
         5'd5:  v = 34'sd21354465;
         5'd6:  v = 34'sd10679838;
         5'd7:  v = 34'sd5340245;
         5'd8:  v = 34'sd2670163;
         5'd9:  v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Product of two Q30 values, rounded half up back to Q30.
   function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] p;
      p = a * b + (68'sd1 <<< 29);
      return p[CW+29:30];
   endfunction

endpackage

/* rtl/estm_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one set of transform parameters a beat.
// ----------------------------------------------------------------------------
interface estm_req_if;
   import estm_pkg::*;
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/estm_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one 3x4 transform a beat.
// ----------------------------------------------------------------------------
interface estm_rsp_if;
   import estm_pkg::*;
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/estm_cordic_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC lane
// Pipelined rotation-mode CORDIC, one iteration per stage, giving cos and sin.
// ----------------------------------------------------------------------------
module estm_cordic_lane (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [15:0]                angle,
   output logic signed [estm_pkg::CW-1:0]    cos_val,
   output logic signed [estm_pkg::CW-1:0]    sin_val
);
   import estm_pkg::*;

   logic signed [CW-1:0] st_x [0:NSTEP];
   logic signed [CW-1:0] st_y [0:NSTEP];
   logic signed [CW-1:0] st_z [0:NSTEP];
   logic                 st_n [0:NSTEP];
   logic signed [CW-1:0] x_ff [0:NSTEP-1];
   logic signed [CW-1:0] y_ff [0:NSTEP-1];
   logic signed [CW-1:0] z_ff [0:NSTEP-1];
   logic                 n_ff [0:NSTEP-1];
   logic [1:0]           quad;

   // Quadrant fold: the second and third quadrants move by a half turn.
   assign quad    = angle[15:14];
   assign st_n[0] = (quad == 2'b01) || (quad == 2'b10);
   assign st_x[0] = GAIN_Q30;
   assign st_y[0] = '0;
   assign st_z[0] = CW'({st_n[0] ^ angle[15], angle[14:0], 16'b0}) -
                    (CW'(st_n[0] ^ angle[15]) <<< 32);

   // One micro-rotation per stage.
   for (genvar k = 0; k < NSTEP; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[k] <= st_n[k];
            if (st_z[k] >= 0) begin
               x_ff[k] <= st_x[k] - (st_y[k] >>> k);
               y_ff[k] <= st_y[k] + (st_x[k] >>> k);
               z_ff[k] <= st_z[k] - atan_q30(5'(k));
            end else begin
               x_ff[k] <= st_x[k] + (st_y[k] >>> k);
               y_ff[k] <= st_y[k] - (st_x[k] >>> k);
               z_ff[k] <= st_z[k] + atan_q30(5'(k));
            end
         end
      end
      assign st_x[k+1] = x_ff[k];
      assign st_y[k+1] = y_ff[k];
      assign st_z[k+1] = z_ff[k];
      assign st_n[k+1] = n_ff[k];
   end

   // Undo the fold by negating both results.
   assign cos_val = st_n[NSTEP] ? -st_x[NSTEP] : st_x[NSTEP];
   assign sin_val = st_n[NSTEP] ? -st_y[NSTEP] : st_y[NSTEP];

endmodule

/* rtl/estm_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix merge
// Combines the three lanes' sin and cos into Rz*Ry*Rx and applies the scale.
// ----------------------------------------------------------------------------
module estm_merge (
   input  logic                           clock,
   input  logic                           adv,
   input  logic signed [estm_pkg::CW-1:0] cx,
   input  logic signed [estm_pkg::CW-1:0] sx,
   input  logic signed [estm_pkg::CW-1:0] cy,
   input  logic signed [estm_pkg::CW-1:0] sy,
   input  logic signed [estm_pkg::CW-1:0] cz,
   input  logic signed [estm_pkg::CW-1:0] sz,
   input  logic signed [23:0]             kx,
   input  logic signed [23:0]             ky,
   input  logic signed [23:0]             kz,
   output estm_pkg::rsp_data_type         mat
);
   import estm_pkg::*;

   // Stage A: pair products.
   logic signed [CW-1:0] czsy_ff, szsy_ff, a00_ff, a10_ff, a20_ff, a21_ff, a22_ff;
   logic signed [CW-1:0] szcx_ff, czcx_ff, szsx_ff, czsx_ff, cxa_ff, sxa_ff;
   logic signed [23:0]   kxa_ff, kya_ff, kza_ff;
   // Stage B: rotation entries.
   logic signed [CW-1:0] r00_ff, r01_ff, r02_ff, r10_ff, r11_ff, r12_ff;
   logic signed [CW-1:0] r20_ff, r21_ff, r22_ff;
   logic signed [23:0]   kxb_ff, kyb_ff, kzb_ff;
   // Stage C: scaled outputs.
   rsp_data_type         mat_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         czsy_ff <= mul30(cz, sy);
         szsy_ff <= mul30(sz, sy);
         a00_ff  <= mul30(cz, cy);
         a10_ff  <= mul30(sz, cy);
         a20_ff  <= sy;
         a21_ff  <= mul30(cy, sx);
         a22_ff  <= mul30(cy, cx);
         szcx_ff <= mul30(sz, cx);
         czcx_ff <= mul30(cz, cx);
         szsx_ff <= mul30(sz, sx);
         czsx_ff <= mul30(cz, sx);
         cxa_ff  <= cx;
         sxa_ff  <= sx;
         kxa_ff  <= kx;
         kya_ff  <= ky;
         kza_ff  <= kz;
      end
   end

   // Triple products, each rounded, then summed.
   always_ff @(posedge clock) begin
      if (adv) begin
         r00_ff <= a00_ff;
         r10_ff <= a10_ff;
         r20_ff <= a20_ff;
         r21_ff <= a21_ff;
         r22_ff <= a22_ff;
         r01_ff <= -szcx_ff - mul30(czsy_ff, sxa_ff);
         r11_ff <= czcx_ff - mul30(szsy_ff, sxa_ff);
         r02_ff <= szsx_ff - mul30(czsy_ff, cxa_ff);
         r12_ff <= -czsx_ff - mul30(szsy_ff, cxa_ff);
         kxb_ff <= kxa_ff;
         kyb_ff <= kya_ff;
         kzb_ff <= kza_ff;
      end
   end

   // Scale each column; the rounded product always fits 32 bits.
   always_ff @(posedge clock) begin
      if (adv) begin
         mat_ff.m00 <= 32'(mul30(r00_ff, CW'(kxb_ff)));
         mat_ff.m10 <= 32'(mul30(r10_ff, CW'(kxb_ff)));
         mat_ff.m20 <= 32'(mul30(r20_ff, CW'(kxb_ff)));
         mat_ff.m01 <= 32'(mul30(r01_ff, CW'(kyb_ff)));
         mat_ff.m11 <= 32'(mul30(r11_ff, CW'(kyb_ff)));
         mat_ff.m21 <= 32'(mul30(r21_ff, CW'(kyb_ff)));
         mat_ff.m02 <= 32'(mul30(r02_ff, CW'(kzb_ff)));
         mat_ff.m12 <= 32'(mul30(r12_ff, CW'(kzb_ff)));
         mat_ff.m22 <= 32'(mul30(r22_ff, CW'(kzb_ff)));
         mat_ff.m03 <= '0;
         mat_ff.m13 <= '0;
         mat_ff.m23 <= '0;
      end
   end

   assign mat = mat_ff;

endmodule

/* rtl/euler_scale_translate_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler scale translate matrix
// Builds rows 0 to 2 of Rz*Ry*Rx*S with the translation in column 3.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; three CORDIC lanes run side by side, one
// iteration per stage, and a three-stage merge forms and scales the matrix.
// The whole pipeline holds while a response beat waits to be taken.
// Reset clears the valid pipeline only; data registers are not reset.
module euler_scale_translate_matrix (
   input  logic        clock,
   input  logic        reset,
   estm_req_if.sink    req,
   estm_rsp_if.source  rsp
);
   import estm_pkg::*;

   logic                 adv;
   logic [LAT-1:0]       vld_ff;
   logic [LAT-1:0]       vld_in;
   req_data_type         side_ff [0:LAT-1];
   logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;
   rsp_data_type         mat;

   // Advance whenever the last stage is empty or being taken.
   assign adv       = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = adv;

   assign vld_in = {vld_ff[LAT-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Side data travels alongside the lanes.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= req.data;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   estm_cordic_lane u_lane_x (.clock(clock), .adv(adv), .angle(req.data.angle_x),
                              .cos_val(cx), .sin_val(sx));
   estm_cordic_lane u_lane_y (.clock(clock), .adv(adv), .angle(req.data.angle_y),
                              .cos_val(cy), .sin_val(sy));
   estm_cordic_lane u_lane_z (.clock(clock), .adv(adv), .angle(req.data.angle_z),
                              .cos_val(cz), .sin_val(sz));

   estm_merge u_merge (
      .clock (clock),
      .adv   (adv),
      .cx    (cx), .sx (sx), .cy (cy), .sy (sy), .cz (cz), .sz (sz),
      .kx    (side_ff[NSTEP-1].scale_x),
      .ky    (side_ff[NSTEP-1].scale_y),
      .kz    (side_ff[NSTEP-1].scale_z),
      .mat   (mat)
   );

   // Response beat: merged matrix with translation column.
   always_comb begin
      rsp.data     = mat;
      rsp.data.m03 = side_ff[LAT-1].shift_x;
      rsp.data.m13 = side_ff[LAT-1].shift_y;
      rsp.data.m23 = side_ff[LAT-1].shift_z;
   end
   assign rsp.valid = vld_ff[LAT-1];

`ifndef NO_ASSERTIONS
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("request taken while response stalled");
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp.valid)
      else $error("response valid right after reset");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> vld_ff[0])
      else $error("accepted beat missing from pipeline");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
      else $error("stalled response changed");
`endif

endmodule
